FILE: rtl/rba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rba_pkg: shared types for the region bump allocator
// Request/result payloads, datapath command codes and status flags.
// ----------------------------------------------------------------------------
package rba_pkg;

    localparam int RBA_AVAIL_DEPTH = 256;
    localparam int RBA_RESV_DEPTH  = 256;
    localparam int RBA_PAGE_SHIFT  = 12;

    localparam logic [2:0] REQ_ADD   = 3'd0;
    localparam logic [2:0] REQ_RESV  = 3'd1;
    localparam logic [2:0] REQ_ALLOC = 3'd2;
    localparam logic [2:0] REQ_QUERY = 3'd3;
    localparam logic [2:0] REQ_COUNT = 3'd4;

    localparam logic REG_UPPER_LIMIT = 1'b0;
    localparam logic REG_ALLOC_FLOOR = 1'b1;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] region_base;
        logic [31:0] region_size;
        logic [31:0] align_bytes;
        logic [20:0] first_page;
        logic [20:0] last_page;
    } rba_req_t;

    typedef struct packed {
        logic [31:0] alloc_addr;
        logic        ok;
        logic [20:0] page_count;
    } rba_rsp_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_FIN_ZERO,
        OP_RESV,
        OP_A_INIT,
        OP_Q_INIT,
        OP_C_INIT,
        OP_IDX_CLR,
        OP_A_NEXT,
        OP_A_EVAL,
        OP_R_CLR,
        OP_R_NEXT,
        OP_HIT,
        OP_COMMIT,
        OP_FIN_QHIT,
        OP_C_EVAL,
        OP_C_ACC,
        OP_FIN_CNT,
        OP_D_POS,
        OP_S_WR,
        OP_INS
    } rba_op_t;

    typedef struct packed {
        rba_op_t op;
        logic    rd_prev;
    } rba_cmd_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic       size_zero;
        logic       avail_full;
        logic       ai_end;
        logic       ri_end;
        logic       a_skip;
        logic       a_nofit;
        logic       r_hit;
        logic       c_empty;
        logic       c_skip;
        logic       c_stop;
        logic       d_le;
        logic       s_more;
    } rba_stat_t;

    // (v + m) & ~m, carried to 33 bits
    function automatic logic [32:0] rba_round_up(input logic [31:0] v, input logic [31:0] m);
        logic [32:0] s;
        s = {1'b0, v} + {1'b0, m};
        return s & ~{1'b0, m};
    endfunction

endpackage

FILE: rtl/rba_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rba_dp: allocator datapath
// Region and reservation tables, scan indexes, address arithmetic, results.
// ----------------------------------------------------------------------------
module rba_dp #(
    parameter int AVAIL_DEPTH = rba_pkg::RBA_AVAIL_DEPTH,
    parameter int RESV_DEPTH  = rba_pkg::RBA_RESV_DEPTH,
    parameter int PAGE_SHIFT  = rba_pkg::RBA_PAGE_SHIFT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rba_pkg::rba_cmd_t  cmd,
    input  rba_pkg::rba_req_t  req,
    input  logic [31:0]        upper_limit,
    input  logic [31:0]        alloc_floor,
    output rba_pkg::rba_stat_t stat,
    output logic               done,
    output rba_pkg::rba_rsp_t  result
);
    import rba_pkg::*;

    localparam int AIW = (AVAIL_DEPTH > 1) ? $clog2(AVAIL_DEPTH) : 1;
    localparam int ACW = $clog2(AVAIL_DEPTH + 1);
    localparam int RIW = (RESV_DEPTH > 1) ? $clog2(RESV_DEPTH) : 1;
    localparam int RCW = $clog2(RESV_DEPTH + 1);
    localparam int GW  = $clog2(RESV_DEPTH + 2);
    localparam logic [31:0] PMASK = (32'd1 << PAGE_SHIFT) - 32'd1;

    logic [31:0] av_base_mem [AVAIL_DEPTH];
    logic [31:0] av_size_mem [AVAIL_DEPTH];
    logic [31:0] rv_base_mem [RESV_DEPTH];
    logic [31:0] rv_size_mem [RESV_DEPTH];

    rba_req_t    req_reg;
    logic [ACW-1:0] ai_reg, pos_reg, av_used_reg;
    logic [RCW-1:0] ri_reg, rv_used_reg;
    logic [GW-1:0]  guard_reg;
    logic [31:0] bump_reg, cur_reg, amask_reg, re_reg, sa_reg, ea_reg, hi_reg, pages_reg;
    logic [32:0] a_reg, lo_reg;
    logic        c_empty_reg;
    logic [31:0] ab_q_reg, as_q_reg, rb_q_reg, rs_q_reg;
    logic [31:0] res_addr_reg;
    logic        res_ok_reg;
    logic [20:0] res_cnt_reg;
    logic        done_reg;

    logic [ACW-1:0] av_ra;
    logic [31:0] a_re, r_re, a_lo_base, a_reclip, ov_e;
    logic [32:0] a_rnd, hit_rnd, fit_sum;
    logic [31:0] total, fp32, lp32, lp_c, sa_n, ea_n, ea_c;
    logic [31:0] c_lo_base, c_hi;
    logic [32:0] c_lo, c_diff;
    logic [31:0] amask_n, cur_max;
    logic        rv_full;
    logic        av_we;
    logic [AIW-1:0] av_wa;
    logic [31:0] av_wb, av_ws;
    logic        rv_we;
    logic [31:0] rv_wb;

    assign av_ra = cmd.rd_prev ? (ai_reg - ACW'(1)) : ai_reg;

    always_ff @(posedge clk)
    begin
        ab_q_reg <= av_base_mem[av_ra[AIW-1:0]];
        as_q_reg <= av_size_mem[av_ra[AIW-1:0]];
        rb_q_reg <= rv_base_mem[ri_reg[RIW-1:0]];
        rs_q_reg <= rv_size_mem[ri_reg[RIW-1:0]];
        if (av_we)
        begin
            av_base_mem[av_wa] <= av_wb;
            av_size_mem[av_wa] <= av_ws;
        end
        if (rv_we)
        begin
            rv_base_mem[rv_used_reg[RIW-1:0]] <= rv_wb;
            rv_size_mem[rv_used_reg[RIW-1:0]] <= req_reg.region_size;
        end
    end

    // allocation arithmetic
    assign a_re      = ab_q_reg + as_q_reg;
    assign r_re      = rb_q_reg + rs_q_reg;
    assign a_lo_base = (cur_reg > ab_q_reg) ? cur_reg : ab_q_reg;
    assign a_rnd     = rba_round_up(a_lo_base, amask_reg);
    assign a_reclip  = (a_re > upper_limit) ? upper_limit : a_re;
    assign fit_sum   = {1'b0, a_reg[31:0]} + {1'b0, req_reg.region_size};
    assign ov_e      = a_reg[31:0] + req_reg.region_size;
    assign hit_rnd   = rba_round_up(r_re, amask_reg);
    assign amask_n   = (req_reg.align_bytes == 32'd0) ? PMASK : (req_reg.align_bytes - 32'd1);
    assign cur_max   = (bump_reg > alloc_floor) ? bump_reg : alloc_floor;

    // page count arithmetic
    assign total     = upper_limit >> PAGE_SHIFT;
    assign fp32      = {11'd0, req_reg.first_page};
    assign lp32      = {11'd0, req_reg.last_page};
    assign lp_c      = (lp32 > total) ? total : lp32;
    assign sa_n      = fp32 << PAGE_SHIFT;
    assign ea_n      = lp_c << PAGE_SHIFT;
    assign ea_c      = (ea_n > upper_limit) ? upper_limit : ea_n;
    assign c_lo_base = (ab_q_reg > sa_reg) ? ab_q_reg : sa_reg;
    assign c_lo      = rba_round_up(c_lo_base, PMASK);
    assign c_hi      = ((a_re < ea_reg) ? a_re : ea_reg) & ~PMASK;
    assign c_diff    = {1'b0, hi_reg} - lo_reg;

    assign rv_full = (rv_used_reg >= RCW'(RESV_DEPTH));

    always_comb
    begin
        av_we = 1'b0;
        av_wa = ai_reg[AIW-1:0];
        av_wb = ab_q_reg;
        av_ws = as_q_reg;
        rv_we = 1'b0;
        rv_wb = req_reg.region_base;
        case (cmd.op)
            OP_S_WR:
            begin
                av_we = 1'b1;
            end
            OP_INS:
            begin
                av_we = 1'b1;
                av_wa = pos_reg[AIW-1:0];
                av_wb = req_reg.region_base;
                av_ws = req_reg.region_size;
            end
            OP_RESV:
            begin
                rv_we = !rv_full;
            end
            OP_COMMIT:
            begin
                rv_we = !rv_full;
                rv_wb = a_reg[31:0];
            end
            default:
            begin
                av_we = 1'b0;
            end
        endcase
    end

    // control state: indexes, fill counts, bump pointer, strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ai_reg      <= '0;
            ri_reg      <= '0;
            guard_reg   <= '0;
            av_used_reg <= '0;
            rv_used_reg <= '0;
            bump_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (cmd.op)
                OP_FIN_ZERO, OP_FIN_QHIT, OP_FIN_CNT:
                begin
                    done_reg <= 1'b1;
                end
                OP_RESV:
                begin
                    done_reg <= 1'b1;
                    if (!rv_full)
                    begin
                        rv_used_reg <= rv_used_reg + RCW'(1);
                    end
                end
                OP_COMMIT:
                begin
                    done_reg <= 1'b1;
                    bump_reg <= fit_sum[31:0];
                    if (!rv_full)
                    begin
                        rv_used_reg <= rv_used_reg + RCW'(1);
                    end
                end
                OP_INS:
                begin
                    done_reg    <= 1'b1;
                    av_used_reg <= av_used_reg + ACW'(1);
                end
                OP_A_INIT, OP_C_INIT, OP_IDX_CLR:
                begin
                    ai_reg <= '0;
                end
                OP_Q_INIT, OP_R_CLR:
                begin
                    ri_reg <= '0;
                end
                OP_A_NEXT, OP_C_ACC:
                begin
                    ai_reg <= ai_reg + ACW'(1);
                end
                OP_R_NEXT:
                begin
                    ri_reg <= ri_reg + RCW'(1);
                end
                OP_A_EVAL:
                begin
                    guard_reg <= '0;
                end
                OP_HIT:
                begin
                    guard_reg <= guard_reg + GW'(1);
                end
                OP_D_POS:
                begin
                    ai_reg <= av_used_reg;
                end
                OP_S_WR:
                begin
                    ai_reg <= ai_reg - ACW'(1);
                end
                default:
                begin
                    done_reg <= 1'b0;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                req_reg <= req;
            end
            OP_A_INIT:
            begin
                amask_reg <= amask_n;
                cur_reg   <= (cur_max > upper_limit) ? upper_limit : cur_max;
            end
            OP_A_EVAL:
            begin
                a_reg  <= a_rnd;
                re_reg <= a_reclip;
            end
            OP_HIT:
            begin
                a_reg <= hit_rnd;
            end
            OP_Q_INIT:
            begin
                a_reg <= {1'b0, req_reg.region_base};
            end
            OP_C_INIT:
            begin
                sa_reg      <= sa_n;
                ea_reg      <= ea_c;
                pages_reg   <= '0;
                c_empty_reg <= (fp32 >= lp_c) || (sa_n >= upper_limit);
            end
            OP_C_EVAL:
            begin
                lo_reg <= c_lo;
                hi_reg <= c_hi;
            end
            OP_C_ACC:
            begin
                if ({1'b0, hi_reg} > lo_reg)
                begin
                    pages_reg <= pages_reg + 32'(c_diff >> PAGE_SHIFT);
                end
            end
            OP_D_POS:
            begin
                pos_reg <= ai_reg;
            end
            OP_FIN_ZERO, OP_RESV, OP_INS:
            begin
                res_addr_reg <= '0;
                res_ok_reg   <= 1'b0;
                res_cnt_reg  <= '0;
            end
            OP_FIN_QHIT:
            begin
                res_addr_reg <= '0;
                res_ok_reg   <= 1'b1;
                res_cnt_reg  <= '0;
            end
            OP_COMMIT:
            begin
                res_addr_reg <= a_reg[31:0];
                res_ok_reg   <= 1'b1;
                res_cnt_reg  <= '0;
            end
            OP_FIN_CNT:
            begin
                res_addr_reg <= '0;
                res_ok_reg   <= 1'b0;
                res_cnt_reg  <= pages_reg[20:0];
            end
            default:
            begin
                res_ok_reg <= res_ok_reg;
            end
        endcase
    end

    always_comb
    begin
        stat.req_type   = req_reg.req_type;
        stat.size_zero  = (req_reg.region_size == 32'd0);
        stat.avail_full = (av_used_reg >= ACW'(AVAIL_DEPTH));
        stat.ai_end     = (ai_reg >= av_used_reg);
        stat.ri_end     = (ri_reg >= rv_used_reg);
        stat.a_skip     = (ab_q_reg >= upper_limit);
        stat.a_nofit    = (guard_reg > GW'(RESV_DEPTH)) || a_reg[32]
                          || (a_reg[31:0] >= re_reg) || (fit_sum > {1'b0, re_reg});
        stat.r_hit      = !((ov_e <= rb_q_reg) || (a_reg[31:0] >= r_re));
        stat.c_empty    = c_empty_reg;
        stat.c_skip     = (a_re <= sa_reg);
        stat.c_stop     = (ab_q_reg >= ea_reg);
        stat.d_le       = (ab_q_reg <= req_reg.region_base);
        stat.s_more     = (ai_reg > pos_reg);
    end

    assign done              = done_reg;
    assign result.alloc_addr = res_addr_reg;
    assign result.ok         = res_ok_reg;
    assign result.page_count = res_cnt_reg;

endmodule

FILE: rtl/rba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rba_ctrl: allocator sequencer
// Walks the tables for each request and issues one datapath command a cycle.
// ----------------------------------------------------------------------------
module rba_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  rba_pkg::rba_stat_t stat,
    output rba_pkg::rba_cmd_t  cmd,
    output logic               busy
);
    import rba_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISPATCH,
        ST_D_RD, ST_D_EV, ST_S_CHK, ST_S_RD, ST_S_WR,
        ST_A_RD, ST_A_EV, ST_A_CHK, ST_R_RD, ST_R_EV,
        ST_C_CHK, ST_C_RD, ST_C_EV, ST_C_ACC
    } state_t;

    state_t state_reg, state_next;
    logic   is_query;

    assign is_query = (stat.req_type == REQ_QUERY);

    always_comb
    begin
        state_next  = state_reg;
        cmd.op      = OP_NONE;
        cmd.rd_prev = (state_reg == ST_S_RD) || (state_reg == ST_S_WR);
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                state_next = ST_IDLE;
                case (stat.req_type)
                    REQ_ADD:
                    begin
                        if (stat.avail_full)
                        begin
                            cmd.op = OP_FIN_ZERO;
                        end
                        else
                        begin
                            cmd.op     = OP_IDX_CLR;
                            state_next = ST_D_RD;
                        end
                    end
                    REQ_RESV:
                    begin
                        cmd.op = OP_RESV;
                    end
                    REQ_ALLOC:
                    begin
                        if (stat.size_zero)
                        begin
                            cmd.op = OP_FIN_ZERO;
                        end
                        else
                        begin
                            cmd.op     = OP_A_INIT;
                            state_next = ST_A_RD;
                        end
                    end
                    REQ_QUERY:
                    begin
                        cmd.op     = OP_Q_INIT;
                        state_next = ST_R_RD;
                    end
                    REQ_COUNT:
                    begin
                        cmd.op     = OP_C_INIT;
                        state_next = ST_C_CHK;
                    end
                    default:
                    begin
                        cmd.op = OP_FIN_ZERO;
                    end
                endcase
            end
            ST_D_RD:
            begin
                if (stat.ai_end)
                begin
                    cmd.op     = OP_D_POS;
                    state_next = ST_S_CHK;
                end
                else
                begin
                    state_next = ST_D_EV;
                end
            end
            ST_D_EV:
            begin
                if (stat.d_le)
                begin
                    cmd.op     = OP_A_NEXT;
                    state_next = ST_D_RD;
                end
                else
                begin
                    cmd.op     = OP_D_POS;
                    state_next = ST_S_CHK;
                end
            end
            ST_S_CHK:
            begin
                if (stat.s_more)
                begin
                    state_next = ST_S_RD;
                end
                else
                begin
                    cmd.op     = OP_INS;
                    state_next = ST_IDLE;
                end
            end
            ST_S_RD:
            begin
                state_next = ST_S_WR;
            end
            ST_S_WR:
            begin
                cmd.op     = OP_S_WR;
                state_next = ST_S_CHK;
            end
            ST_A_RD:
            begin
                if (stat.ai_end)
                begin
                    cmd.op     = OP_FIN_ZERO;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_A_EV;
                end
            end
            ST_A_EV:
            begin
                if (stat.a_skip)
                begin
                    cmd.op     = OP_A_NEXT;
                    state_next = ST_A_RD;
                end
                else
                begin
                    cmd.op     = OP_A_EVAL;
                    state_next = ST_A_CHK;
                end
            end
            ST_A_CHK:
            begin
                if (stat.a_nofit)
                begin
                    cmd.op     = OP_A_NEXT;
                    state_next = ST_A_RD;
                end
                else
                begin
                    cmd.op     = OP_R_CLR;
                    state_next = ST_R_RD;
                end
            end
            ST_R_RD:
            begin
                if (stat.ri_end)
                begin
                    cmd.op     = is_query ? OP_FIN_ZERO : OP_COMMIT;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_R_EV;
                end
            end
            ST_R_EV:
            begin
                if (stat.r_hit && is_query)
                begin
                    cmd.op     = OP_FIN_QHIT;
                    state_next = ST_IDLE;
                end
                else if (stat.r_hit)
                begin
                    cmd.op     = OP_HIT;
                    state_next = ST_A_CHK;
                end
                else
                begin
                    cmd.op     = OP_R_NEXT;
                    state_next = ST_R_RD;
                end
            end
            ST_C_CHK:
            begin
                if (stat.c_empty)
                begin
                    cmd.op     = OP_FIN_CNT;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_C_RD;
                end
            end
            ST_C_RD:
            begin
                if (stat.ai_end)
                begin
                    cmd.op     = OP_FIN_CNT;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_C_EV;
                end
            end
            ST_C_EV:
            begin
                if (stat.c_skip)
                begin
                    cmd.op     = OP_A_NEXT;
                    state_next = ST_C_RD;
                end
                else if (stat.c_stop)
                begin
                    cmd.op     = OP_FIN_CNT;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.op     = OP_C_EVAL;
                    state_next = ST_C_ACC;
                end
            end
            ST_C_ACC:
            begin
                cmd.op     = OP_C_ACC;
                state_next = ST_C_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

FILE: rtl/region_bump_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_bump_allocator: boot-time memory region allocator
// Sorted table of available regions, table of reservations, bump allocation.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// follows, shown on result for the single cycle that done is high. The
// receiver cannot stall, so capture result on done. busy is high from the
// cycle after the transfer up to the cycle before done; a new request can be
// taken at the edge that ends the done cycle. Every table entry is read
// through one registered memory port, so each visited entry takes a read state
// and an evaluate state, and a count adds an accumulate state. Steps after the
// dispatch step:
//   reserve, unused codes, add to a full table, zero-size allocate: finished there
//   add: scan for the insert position, shift the later entries up, insert
//   query: walk the reservations until one overlaps or the table ends
//   count: walk the regions, summing whole pages, until they end or pass the range
//   allocate: for each region, a fit check and then a walk of the reservations;
//   each hit moves the address and repeats the fit check, up to RESV_DEPTH+1
//   times per region; the first fit without a hit is committed.
// upper_limit and alloc_floor are written over the APB port at byte addresses
// 0 and 4. The user must write them only while the block is idle; the block
// itself does not enforce it.
// ----------------------------------------------------------------------------
module region_bump_allocator #(
    parameter int AVAIL_DEPTH = rba_pkg::RBA_AVAIL_DEPTH,
    parameter int RESV_DEPTH  = rba_pkg::RBA_RESV_DEPTH,
    parameter int PAGE_SHIFT  = rba_pkg::RBA_PAGE_SHIFT
) (
    input  logic              clk,
    input  logic              rst_n,
    // request channel
    input  logic              start,
    output logic              busy,
    input  rba_pkg::rba_req_t req,
    // result channel
    output logic              done,
    output rba_pkg::rba_rsp_t result,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import rba_pkg::*;

    logic [31:0] upper_limit_reg;
    logic [31:0] alloc_floor_reg;
    logic        cfg_wr;
    rba_cmd_t    cmd;
    rba_stat_t   stat;
    logic        ctrl_busy;

    // register select is paddr[2]; the low two address bits are ignored
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_limit_reg <= '0;
            alloc_floor_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_UPPER_LIMIT)
            begin
                upper_limit_reg <= pwdata;
            end
            else
            begin
                alloc_floor_reg <= pwdata;
            end
        end
    end

    assign prdata = (paddr[2] == REG_ALLOC_FLOOR) ? alloc_floor_reg
                  : (paddr[1:0] == 2'b00) ? upper_limit_reg : upper_limit_reg;

    // sequencer: one datapath command per cycle
    rba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (ctrl_busy)
    );

    // tables, arithmetic and the result register
    rba_dp #(
        .AVAIL_DEPTH (AVAIL_DEPTH),
        .RESV_DEPTH  (RESV_DEPTH),
        .PAGE_SHIFT  (PAGE_SHIFT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .req         (req),
        .upper_limit (upper_limit_reg),
        .alloc_floor (alloc_floor_reg),
        .stat        (stat),
        .done        (done),
        .result      (result)
    );

    assign busy = ctrl_busy;

endmodule

FILE: rtl/rba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rba_checker: port-level checks for the region bump allocator
// Transfer/result ordering and result field consistency.
// ----------------------------------------------------------------------------
module rba_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input rba_pkg::rba_rsp_t result
);

    // accepted request occupies the block
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after request transfer");

    // result comes once the block is free
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // done drops again after each result
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // a nonzero address only comes from a successful allocation
    a_addr_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.alloc_addr != 32'd0) |-> result.ok && (result.page_count == 21'd0))
        else $error("address returned without success");

    // page count results carry no flag
    a_cnt_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.page_count != 21'd0) |-> !result.ok)
        else $error("page count with ok set");

endmodule

bind region_bump_allocator rba_checker u_rba_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: region bump allocator, self-checking
// Drives add/reserve/allocate/query/count requests with random gaps, mirrors
// both region tables and the bump pointer in a scoreboard class, and checks
// every result field against its own prediction. The upper limit and the
// allocation floor are rewritten over APB between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
    import rba_pkg::*;

    localparam int          CYCLE_LIMIT = 50_000_000;
    localparam logic [31:0] PG_BYTES    = 32'd1 << RBA_PAGE_SHIFT;
    localparam logic [31:0] PG_MASK     = PG_BYTES - 32'd1;
    localparam logic [2:0]  REQ_LAST    = REQ_COUNT;   // codes above are unused
    localparam logic [20:0] PAGE_TOP    = 21'd1048576;

    // ------------------------------------------------------------------------
    // Scoreboard: owns a copy of the allocator state and predicts each result
    // ------------------------------------------------------------------------
    class region_book;
        logic [31:0] av_base [RBA_AVAIL_DEPTH];
        logic [31:0] av_size [RBA_AVAIL_DEPTH];
        int          av_cnt;
        logic [31:0] rs_base [RBA_RESV_DEPTH];
        logic [31:0] rs_size [RBA_RESV_DEPTH];
        int          rs_cnt;
        logic [31:0] bump;
        logic [31:0] upper;
        logic [31:0] low_start;
        rba_rsp_t    owed_results [$];
        int          mismatches;

        function new();
            av_cnt = 0;
            rs_cnt = 0;
            bump = '0;
            upper = '0;
            low_start = '0;
            mismatches = 0;
        endfunction

        // (v + (a-1)) & ~(a-1), wide enough that nothing carries out
        function automatic logic [63:0] round_to(logic [63:0] v, logic [31:0] a);
            logic [63:0] m;
            m = {32'd0, a - 32'd1};
            return (v + m) & ~m;
        endfunction

        function automatic void book_resv(logic [31:0] b, logic [31:0] s);
            if (rs_cnt >= RBA_RESV_DEPTH)
                return;
            rs_base[rs_cnt] = b;
            rs_size[rs_cnt] = s;
            rs_cnt++;
        endfunction

        // first reservation overlapping [b, b+s), with its wrapped end
        function automatic bit resv_hit(logic [31:0] b, logic [31:0] s,
                                        output logic [31:0] hit_end);
            logic [31:0] e;
            logic [31:0] re;
            e = b + s;
            hit_end = '0;
            for (int i = 0; i < rs_cnt; i++)
            begin
                re = rs_base[i] + rs_size[i];
                if (e <= rs_base[i] || b >= re)
                    continue;
                hit_end = re;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // sorted insert, after any entry with the same base
        function automatic void book_avail(logic [31:0] b, logic [31:0] s);
            int pos;
            if (av_cnt >= RBA_AVAIL_DEPTH)
                return;
            pos = 0;
            while (pos < av_cnt && av_base[pos] <= b)
                pos++;
            for (int k = av_cnt; k > pos; k--)
            begin
                av_base[k] = av_base[k-1];
                av_size[k] = av_size[k-1];
            end
            av_base[pos] = b;
            av_size[pos] = s;
            av_cnt++;
        endfunction

        function automatic logic [31:0] carve(logic [31:0] sz, logic [31:0] align,
                                              output logic ok);
            logic [31:0] al;
            logic [31:0] cur;
            logic [31:0] rb;
            logic [31:0] re;
            logic [31:0] hit;
            logic [63:0] a;
            al = (align != 0) ? align : PG_BYTES;
            cur = (bump > low_start) ? bump : low_start;
            ok = 1'b0;
            if (sz == 0)
                return '0;
            if (cur > upper)
                cur = upper;
            for (int i = 0; i < av_cnt; i++)
            begin
                rb = av_base[i];
                re = rb + av_size[i];
                if (rb >= upper)
                    continue;
                if (re > upper)
                    re = upper;
                a = round_to({32'd0, (cur > rb) ? cur : rb}, al);
                // each hit restarts the walk; bounded like the hardware
                for (int g = 0; g <= RBA_RESV_DEPTH; g++)
                begin
                    if (a > 64'hFFFF_FFFF || a >= {32'd0, re} || a + sz > {32'd0, re})
                        break;
                    if (resv_hit(a[31:0], sz, hit))
                    begin
                        a = round_to({32'd0, hit}, al);
                        continue;
                    end
                    bump = a[31:0] + sz;
                    book_resv(a[31:0], sz);
                    ok = 1'b1;
                    return a[31:0];
                end
            end
            return '0;
        endfunction

        function automatic logic [31:0] whole_pages(logic [31:0] fp, logic [31:0] lp);
            logic [31:0] total;
            logic [31:0] sa;
            logic [31:0] ea;
            logic [31:0] pages;
            logic [31:0] rb;
            logic [31:0] re;
            logic [63:0] lo;
            logic [63:0] hi;
            total = upper >> RBA_PAGE_SHIFT;
            pages = '0;
            if (lp > total)
                lp = total;
            if (fp >= lp)
                return '0;
            sa = fp << RBA_PAGE_SHIFT;
            ea = lp << RBA_PAGE_SHIFT;
            if (sa >= upper)
                return '0;
            if (ea > upper)
                ea = upper;
            for (int i = 0; i < av_cnt; i++)
            begin
                rb = av_base[i];
                re = rb + av_size[i];
                if (re <= sa)
                    continue;
                if (rb >= ea)
                    break;
                lo = round_to({32'd0, (rb > sa) ? rb : sa}, PG_BYTES);
                hi = {32'd0, (re < ea) ? re : ea} & ~{32'd0, PG_MASK};
                if (hi > lo)
                    pages += 32'((hi - lo) >> RBA_PAGE_SHIFT);
            end
            return pages;
        endfunction

        // accepted request: update state and queue the result it owes
        function automatic void note_request(rba_req_t r);
            rba_rsp_t    exp;
            logic        ok;
            logic [31:0] hit;
            logic [31:0] cnt;
            exp = '0;
            case (r.req_type)
                REQ_ADD:   book_avail(r.region_base, r.region_size);
                REQ_RESV:  book_resv(r.region_base, r.region_size);
                REQ_ALLOC:
                begin
                    exp.alloc_addr = carve(r.region_size, r.align_bytes, ok);
                    exp.ok = ok;
                end
                REQ_QUERY: exp.ok = resv_hit(r.region_base, r.region_size, hit);
                REQ_COUNT:
                begin
                    cnt = whole_pages({11'd0, r.first_page}, {11'd0, r.last_page});
                    exp.page_count = cnt[20:0];
                end
                default: ;
            endcase
            owed_results.push_back(exp);
        endfunction

        function automatic void check_result(rba_rsp_t got);
            rba_rsp_t exp;
            if (owed_results.size() == 0)
            begin
                $display("%0t: unexpected result addr=%h ok=%b pages=%0d",
                         $time, got.alloc_addr, got.ok, got.page_count);
                mismatches++;
                return;
            end
            exp = owed_results.pop_front();
            if (got.alloc_addr !== exp.alloc_addr)
            begin
                $display("%0t: alloc_addr expected %h actual %h",
                         $time, exp.alloc_addr, got.alloc_addr);
                mismatches++;
            end
            if (got.ok !== exp.ok)
            begin
                $display("%0t: ok expected %b actual %b", $time, exp.ok, got.ok);
                mismatches++;
            end
            if (got.page_count !== exp.page_count)
            begin
                $display("%0t: page_count expected %0d actual %0d",
                         $time, exp.page_count, got.page_count);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    rba_req_t    req;
    logic        done;
    rba_rsp_t    result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    region_bump_allocator i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    region_book book = new();
    int         cycles;
    bit         bursty;     // phase-level switch: no gaps between transfers

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // watchdog
    initial
    begin
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result monitor: done is a one-cycle strobe, no backpressure possible
    always @(posedge clk)
    begin
        if (rst_n && done)
            book.check_result(result);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // APB write: setup cycle, then access cycle; pready is tied high
    task automatic reg_write(logic idx, logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_UPPER_LIMIT)
            book.upper = val;
        else
            book.low_start = val;
    endtask

    task automatic drain();
        while (book.owed_results.size() != 0)
            @(posedge clk);
    endtask

    // quiesce, then retune both limits
    task automatic retune(logic [31:0] lim, logic [31:0] lo);
        @(posedge clk);
        start <= 1'b0;
        drain();
        reg_write(REG_UPPER_LIMIT, lim);
        reg_write(REG_ALLOC_FLOOR, lo);
    endtask

    // one request transfer; start stays high into the next call when no gap
    task automatic issue(rba_req_t r);
        int gap;
        int pick;
        gap = 0;
        if (!bursty)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                gap = $urandom_range(10, 60);
            else if (pick < 45)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        book.note_request(r);
    endtask

    function automatic rba_req_t mk(logic [2:0] kind, logic [31:0] b, logic [31:0] s,
                                    logic [31:0] al, logic [20:0] fp, logic [20:0] lp);
        rba_req_t r;
        r.req_type    = kind;
        r.region_base = b;
        r.region_size = s;
        r.align_bytes = al;
        r.first_page  = fp;
        r.last_page   = lp;
        return r;
    endfunction

    function automatic logic [31:0] pick_align();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40)
            return '0;
        if (p < 80)
            return 32'd1 << $urandom_range(0, 16);
        if (p < 90)
            return 32'd1 << $urandom_range(17, 31);
        return $urandom_range(0, 32'h8000_0000);   // not a power of two, mostly
    endfunction

    // random request, weighted toward traffic that stays near the bump pointer
    function automatic rba_req_t rand_req();
        rba_req_t    r;
        int          p;
        logic [31:0] near;
        logic [20:0] fp;
        p = $urandom_range(0, 99);
        near = book.bump + $urandom_range(0, 32'h2_0000);
        r = mk(REQ_ADD, $urandom, $urandom, pick_align(),
               21'($urandom_range(0, PAGE_TOP)), 21'($urandom_range(0, PAGE_TOP)));
        if (p < 5)
        begin
            // keep regions ahead of the bump so allocation stays alive
            if ($urandom_range(0, 1))
                r.region_base = near;
            r.region_size = $urandom_range(PG_BYTES, 32'h0100_0000);
        end
        else if (p < 20)
        begin
            r.req_type = REQ_RESV;
            if ($urandom_range(0, 3) != 0)
            begin
                r.region_base = near;
                r.region_size = $urandom_range(1, 32'h8000);
            end
        end
        else if (p < 55)
        begin
            r.req_type = REQ_ALLOC;
            p = $urandom_range(0, 9);
            if (p < 7)
                r.region_size = $urandom_range(1, 32'h4000);
            else if (p == 7)
                r.region_size = '0;
            else if (p == 8)
                r.region_size = $urandom_range(1, 32'h10_0000);
        end
        else if (p < 75)
        begin
            r.req_type = REQ_QUERY;
            if ($urandom_range(0, 2) != 0)
            begin
                r.region_base = near - 32'h1_0000;
                r.region_size = $urandom_range(0, 32'h2_0000);
            end
        end
        else if (p < 95)
        begin
            r.req_type = REQ_COUNT;
            if ($urandom_range(0, 1))
            begin
                fp = 21'($urandom_range(0, PAGE_TOP));
                r.first_page = fp;
                r.last_page  = (fp > PAGE_TOP - 21'd8192) ? PAGE_TOP
                                                          : fp + 21'($urandom_range(0, 8192));
            end
        end
        else
        begin
            r.req_type = REQ_LAST + 3'($urandom_range(1, 3));
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    logic [31:0] phase_lim [6];
    logic [31:0] phase_low [6];

    initial
    begin
        start   <= 1'b0;
        req     <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        rst_n   <= 1'b0;
        bursty  = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        reg_write(REG_UPPER_LIMIT, 32'h8000_0000);
        reg_write(REG_ALLOC_FLOOR, 32'h0010_0000);

        // directed: empty tables first
        issue(mk(REQ_COUNT, '0, '0, '0, '0, PAGE_TOP));
        issue(mk(REQ_ALLOC, '0, 32'h1000, '0, '0, '0));
        // region set: low memory, main, an equal base, a wrapping end,
        // one crossing the upper limit, one high region
        issue(mk(REQ_ADD, 32'h0000_0000, 32'h0009_F000, '0, '0, '0));
        issue(mk(REQ_ADD, 32'h0010_0000, 32'h3FF0_0000, '0, '0, '0));
        issue(mk(REQ_ADD, 32'h0010_0000, 32'h0000_0100, '0, '0, '0));
        issue(mk(REQ_ADD, 32'hFFFF_F000, 32'hFFFF_FFFF, '0, '0, '0));
        issue(mk(REQ_ADD, 32'h7000_0000, 32'h2000_0000, '0, '0, '0));
        issue(mk(REQ_ADD, 32'h4000_0000, 32'h1000_0000, '0, '0, '0));
        // reservation on top of the start so the next sized allocation collides
        issue(mk(REQ_RESV, 32'h0010_0000, 32'h0002_0000, '0, '0, '0));
        issue(mk(REQ_RESV, 32'hFFFF_FFF0, 32'h0000_0100, '0, '0, '0));
        issue(mk(REQ_ALLOC, '0, '0, '0, '0, '0));
        issue(mk(REQ_ALLOC, '0, 32'h1000, '0, '0, '0));
        issue(mk(REQ_ALLOC, '0, 32'h1800, 32'h3000, '0, '0));
        issue(mk(REQ_ALLOC, '0, 32'h10, 32'h8000_0000, '0, '0));
        issue(mk(REQ_ALLOC, '0, 32'hFFFF_FFFF, 32'h1, '0, '0));
        issue(mk(REQ_QUERY, 32'h0011_0000, 32'h10, '0, '0, '0));
        issue(mk(REQ_QUERY, 32'h0000_1000, 32'h1000, '0, '0, '0));
        issue(mk(REQ_QUERY, 32'h0011_0000, '0, '0, '0, '0));
        issue(mk(REQ_COUNT, '0, '0, '0, '0, '0));
        issue(mk(REQ_COUNT, '0, '0, '0, 21'd300, 21'd100));
        issue(mk(REQ_COUNT, '0, '0, '0, 21'd1, PAGE_TOP));
        for (int k = 1; k <= 3; k++)
            issue(mk(REQ_LAST + 3'(k), $urandom, $urandom, $urandom, 21'h1FFFFF, 21'h1FFFFF));

        // random phases, each under its own limits
        phase_lim[0] = 32'h8000_0000;  phase_low[0] = 32'h0010_0000;
        phase_lim[1] = 32'hFFFF_FFFF;  phase_low[1] = 32'h0000_0000;
        phase_lim[2] = 32'h0000_0000;  phase_low[2] = 32'h0000_0000;
        phase_lim[3] = 32'hFFFF_FFFF;  phase_low[3] = 32'hFFFF_FFFF;
        phase_lim[4] = 32'h4000_0000;  phase_low[4] = 32'h2000_0000;
        phase_lim[5] = $urandom;       phase_low[5] = $urandom_range(0, 32'h1000_0000);
        for (int ph = 0; ph < 6; ph++)
        begin
            retune(phase_lim[ph], phase_low[ph]);
            bursty = (ph == 2) || (ph == 4);
            for (int n = 0; n < 100; n++)
                issue(rand_req());
        end

        // fill the available table past capacity, then use it
        retune(32'hFFFF_FFFF, 32'h0010_0000);
        bursty = 1'b1;
        while (book.av_cnt < RBA_AVAIL_DEPTH)
            issue(mk(REQ_ADD, $urandom, $urandom_range(1, 32'h1_0000), '0, '0, '0));
        issue(mk(REQ_ADD, 32'h0000_0000, 32'h1000, '0, '0, '0));
        issue(mk(REQ_ADD, 32'hFFFF_FFFF, 32'h1000, '0, '0, '0));
        bursty = 1'b0;
        for (int n = 0; n < 3; n++)
            issue(mk(REQ_ALLOC, '0, $urandom_range(1, 32'h2000), '0, '0, '0));
        issue(mk(REQ_COUNT, '0, '0, '0, '0, PAGE_TOP));
        issue(mk(REQ_QUERY, book.bump, 32'h1000, '0, '0, '0));

        @(posedge clk);
        start <= 1'b0;
        drain();
        repeat (20) @(posedge clk);
        if (book.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/rba_pkg.sv
rtl/rba_dp.sv
rtl/rba_ctrl.sv
rtl/region_bump_allocator.sv
rtl/rba_checker.sv
dv/testbench.sv
